FILE: design/ipid_pkg.sv
// Package for the incremental PID controller: widths, types, register indexes
// and the 32-bit saturation function. No dependencies.
package ipid_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int TIME_W    = 31;
   localparam int RATIO_W   = 30;
   localparam int ONE       = 1 << FRAC_BITS;

   localparam int DVD_STEPS = TIME_W + FRAC_BITS;
   localparam int DVD_CNT_W = $clog2(DVD_STEPS);

   localparam int MUL_A_W     = DATA_W + 1;
   localparam int MUL_B_W     = DATA_W + 1;
   localparam int DIGIT_W     = 4;
   localparam int MUL_DIGITS  = (MUL_B_W + DIGIT_W - 1) / DIGIT_W;
   localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
   localparam int MUL_EXT_W   = MUL_DIGITS * DIGIT_W;
   localparam int MUL_ACC_W   = MUL_A_W + DIGIT_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int SCALED_W    = PROD_W - FRAC_BITS;
   localparam int MUL_LO_W    = MUL_EXT_W - FRAC_BITS;
   localparam int MUL_HI_W    = SCALED_W - MUL_LO_W;
   localparam int SUM_W       = SCALED_W + 3;

   localparam int CSR_IDX_W = 3;

   typedef logic signed [DATA_W-1:0]    word_type;
   typedef logic signed [DATA_W:0]      diff_type;
   typedef logic [TIME_W-1:0]           time_type;
   typedef logic [RATIO_W-1:0]          ratio_type;
   typedef logic signed [MUL_A_W-1:0]   mul_a_type;
   typedef logic signed [MUL_B_W-1:0]   mul_b_type;
   typedef logic signed [MUL_B_W:0]     linear_type;
   typedef logic signed [SCALED_W-1:0]  scaled_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic [DVD_CNT_W-1:0]        dvd_cnt_type;
   typedef logic [MUL_CNT_W-1:0]        mul_cnt_type;
   typedef logic [CSR_IDX_W-1:0]        csr_index_type;

   localparam time_type    TIME_ONE  = time_type'(ONE);
   localparam linear_type  ONE_L     = linear_type'(ONE);
   localparam ratio_type   RATIO_CAP = {RATIO_W{1'b1}};
   localparam dvd_cnt_type DVD_LAST  = dvd_cnt_type'(DVD_STEPS - 1);
   localparam mul_cnt_type MUL_LAST  = mul_cnt_type'(MUL_DIGITS - 1);

   localparam csr_index_type CSR_SETPOINT        = csr_index_type'(0);
   localparam csr_index_type CSR_GAIN            = csr_index_type'(1);
   localparam csr_index_type CSR_SAMPLE_PERIOD   = csr_index_type'(2);
   localparam csr_index_type CSR_DERIVATIVE_TIME = csr_index_type'(3);
   localparam csr_index_type CSR_INTEGRAL_TIME   = csr_index_type'(4);

   localparam sum_type SAT_MAX = {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam sum_type SAT_MIN = {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef struct packed {
      logic     start;
      time_type num;
      time_type den;
   } div_req_type;

   typedef struct packed {
      logic      start;
      mul_a_type a;
      mul_b_type b;
   } mul_req_type;

   typedef struct packed {
      logic     clip;
      word_type value;
   } sat_type;

   function automatic sat_type sat32(input sum_type v);
      sat_type r;
      r.clip  = 1'b0;
      r.value = v[DATA_W-1:0];
      if (v > SAT_MAX) begin
         r.clip  = 1'b1;
         r.value = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r.clip  = 1'b1;
         r.value = SAT_MIN[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/ipid_div.sv
// Bit-serial restoring divider for the controller's time-constant ratios.
// Computes floor((num << FRAC_BITS) / den), capped; uses ipid_pkg.
module ipid_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ipid_pkg::div_req_type      req,
   output ipid_pkg::unit_status_type  status,
   output ipid_pkg::ratio_type        ratio
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   ipid_pkg::dvd_cnt_type  cnt_ff, cnt_in;
   ipid_pkg::time_type     rem_ff, rem_in;
   ipid_pkg::time_type     dvd_ff, dvd_in;
   ipid_pkg::time_type     den_ff, den_in;
   ipid_pkg::ratio_type    quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;

   logic [ipid_pkg::TIME_W:0]   partial;
   logic [ipid_pkg::TIME_W+1:0] diff;
   logic                        fits;

   always_comb begin
      partial = {rem_ff, dvd_ff[ipid_pkg::TIME_W-1]};
      diff    = {1'b0, partial} - {2'b00, den_ff};
      fits    = ~diff[ipid_pkg::TIME_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = req.num;
         den_in  = (req.den == '0) ? ipid_pkg::time_type'(1) : req.den;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ipid_pkg::TIME_W-1:0] : partial[ipid_pkg::TIME_W-1:0];
         dvd_in = {dvd_ff[ipid_pkg::TIME_W-2:0], 1'b0};
         quo_in = {quo_ff[ipid_pkg::RATIO_W-2:0], fits};
         ovf_in = ovf_ff | quo_ff[ipid_pkg::RATIO_W-1];
         cnt_in = cnt_ff + ipid_pkg::dvd_cnt_type'(1);
         if (cnt_ff == ipid_pkg::DVD_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
      ratio       = ovf_ff ? ipid_pkg::RATIO_CAP : quo_ff;
   end

endmodule

FILE: design/ipid_mul.sv
// Digit-serial signed multiplier, four multiplier bits per cycle, LSB first.
// Returns the product shifted right by FRAC_BITS (floor); uses ipid_pkg.
module ipid_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  ipid_pkg::mul_req_type      req,
   output ipid_pkg::unit_status_type  status,
   output ipid_pkg::scaled_type       scaled
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   ipid_pkg::mul_cnt_type                  cnt_ff, cnt_in;
   ipid_pkg::mul_a_type                    a_ff, a_in;
   logic [ipid_pkg::MUL_EXT_W-1:0]         b_ff, b_in;
   logic signed [ipid_pkg::MUL_ACC_W-1:0]  acc_ff, acc_in;
   logic [ipid_pkg::MUL_LO_W-1:0]          lo_ff, lo_in;

   logic [ipid_pkg::DIGIT_W-1:0]           digit;
   logic signed [ipid_pkg::DIGIT_W:0]      digit_sx;
   logic signed [ipid_pkg::MUL_ACC_W-1:0]  pp;
   logic signed [ipid_pkg::MUL_ACC_W-1:0]  sum;
   logic                                   last;

   always_comb begin
      last     = (cnt_ff == ipid_pkg::MUL_LAST);
      digit    = b_ff[ipid_pkg::DIGIT_W-1:0];
      digit_sx = last ? {digit[ipid_pkg::DIGIT_W-1], digit} : {1'b0, digit};
      pp       = ipid_pkg::MUL_ACC_W'(a_ff) * ipid_pkg::MUL_ACC_W'(digit_sx);
      sum      = acc_ff + pp;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = req.a;
         b_in    = ipid_pkg::MUL_EXT_W'(req.b);
         acc_in  = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         acc_in = sum >>> ipid_pkg::DIGIT_W;
         lo_in  = {sum[ipid_pkg::DIGIT_W-1:0], lo_ff[ipid_pkg::MUL_LO_W-1:ipid_pkg::DIGIT_W]};
         b_in   = b_ff >> ipid_pkg::DIGIT_W;
         cnt_in = cnt_ff + ipid_pkg::mul_cnt_type'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = done_ff;
      scaled      = {acc_ff[ipid_pkg::MUL_HI_W-1:0], lo_ff};
   end

endmodule

FILE: design/incremental_pid_controller.sv
// Top level of the incremental PID controller: registers, sequencer and output stage.
// Depends on ipid_pkg, ipid_div and ipid_mul.
//
// Each measurement item yields one drive item after three digit-serial multiplications
// through the shared multiplier plus the accumulator update. The first item after reset,
// or after a write to the gain or to any time constant, first rebuilds q0, q1 and q2,
// which adds two bit-serial divisions and three more multiplications. One item is in
// work at a time; the drive output is registered, so the next item is accepted while
// a result waits.
// Register writes are always accepted and should be made only while the block is idle.
module incremental_pid_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ipid_pkg::DATA_W-1:0] req_measurement,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [ipid_pkg::DATA_W-1:0] rsp_drive,
   output logic                             rsp_saturated,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ipid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ipid_pkg::DATA_W-1:0]      csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_DIV_D  = 11'b000_0000_0010,
      ST_DIV_I  = 11'b000_0000_0100,
      ST_MUL_Q0 = 11'b000_0000_1000,
      ST_MUL_Q1 = 11'b000_0001_0000,
      ST_MUL_Q2 = 11'b000_0010_0000,
      ST_MUL_E0 = 11'b000_0100_0000,
      ST_MUL_E1 = 11'b000_1000_0000,
      ST_MUL_E2 = 11'b001_0000_0000,
      ST_UPDATE = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   state_type                  state_ff, state_in;
   logic                       dirty_ff, dirty_in;
   ipid_pkg::word_type         setpoint_ff, setpoint_in;
   ipid_pkg::word_type         gain_ff, gain_in;
   ipid_pkg::time_type         period_ff, period_in;
   ipid_pkg::time_type         dtime_ff, dtime_in;
   ipid_pkg::time_type         itime_ff, itime_in;
   ipid_pkg::ratio_type        rd_ff, rd_in;
   ipid_pkg::ratio_type        ri_ff, ri_in;
   ipid_pkg::word_type         q0_ff, q0_in;
   ipid_pkg::word_type         q1_ff, q1_in;
   ipid_pkg::word_type         q2_ff, q2_in;
   ipid_pkg::word_type         e_ff, e_in;
   ipid_pkg::word_type         e1_ff, e1_in;
   ipid_pkg::word_type         e2_ff, e2_in;
   ipid_pkg::word_type         u_ff, u_in;
   ipid_pkg::sum_type          sum_ff, sum_in;
   logic                       clip_ff, clip_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ipid_pkg::word_type         rsp_drive_ff, rsp_drive_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   ipid_pkg::div_req_type      div_req;
   ipid_pkg::unit_status_type  div_stat;
   ipid_pkg::ratio_type        div_ratio;
   ipid_pkg::mul_req_type      mul_req;
   ipid_pkg::unit_status_type  mul_stat;
   ipid_pkg::scaled_type       mul_scaled;

   ipid_pkg::diff_type         err_diff;
   ipid_pkg::sat_type          err_sat;
   ipid_pkg::sat_type          q_sat;
   ipid_pkg::sat_type          u_sat;
   ipid_pkg::mul_a_type        gain_a;
   ipid_pkg::linear_type       lin_q1;
   ipid_pkg::mul_b_type        b_q0;
   ipid_pkg::mul_b_type        b_q1;
   ipid_pkg::mul_b_type        b_q2;
   ipid_pkg::sum_type          sum_next;

   ipid_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_stat),
      .ratio  (div_ratio)
   );

   ipid_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .status (mul_stat),
      .scaled (mul_scaled)
   );

   always_comb begin
      err_diff = ipid_pkg::diff_type'(setpoint_ff) - ipid_pkg::diff_type'(req_measurement);
      err_sat  = ipid_pkg::sat32(ipid_pkg::sum_type'(err_diff));
      q_sat    = ipid_pkg::sat32(ipid_pkg::sum_type'(mul_scaled));
      u_sat    = ipid_pkg::sat32(ipid_pkg::sum_type'(u_ff) + sum_ff);
      sum_next = sum_ff + ipid_pkg::sum_type'(mul_scaled);
      gain_a   = ipid_pkg::mul_a_type'(gain_ff);
      lin_q1   = ipid_pkg::ONE_L + ipid_pkg::linear_type'({rd_ff, 1'b0})
                 - ipid_pkg::linear_type'(ri_ff);
      b_q0     = ipid_pkg::mul_b_type'(ipid_pkg::ONE_L + ipid_pkg::linear_type'(rd_ff));
      b_q1     = ipid_pkg::mul_b_type'(-lin_q1);
      b_q2     = ipid_pkg::mul_b_type'(rd_ff);

      state_in     = state_ff;
      dirty_in     = dirty_ff;
      setpoint_in  = setpoint_ff;
      gain_in      = gain_ff;
      period_in    = period_ff;
      dtime_in     = dtime_ff;
      itime_in     = itime_ff;
      rd_in        = rd_ff;
      ri_in        = ri_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      e_in         = e_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      u_in         = u_ff;
      sum_in       = sum_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      div_req      = '0;
      mul_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               e_in   = err_sat.value;
               sum_in = '0;
               if (dirty_ff) begin
                  div_req.start = 1'b1;
                  div_req.num   = dtime_ff;
                  div_req.den   = period_ff;
                  state_in      = ST_DIV_D;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = ipid_pkg::mul_a_type'(q0_ff);
                  mul_req.b     = ipid_pkg::mul_b_type'(err_sat.value);
                  state_in      = ST_MUL_E0;
               end
            end
         end
         ST_DIV_D: begin
            if (div_stat.done) begin
               rd_in         = div_ratio;
               div_req.start = 1'b1;
               div_req.num   = period_ff;
               div_req.den   = itime_ff;
               state_in      = ST_DIV_I;
            end
         end
         ST_DIV_I: begin
            if (div_stat.done) begin
               ri_in         = div_ratio;
               mul_req.start = 1'b1;
               mul_req.a     = gain_a;
               mul_req.b     = b_q0;
               state_in      = ST_MUL_Q0;
            end
         end
         ST_MUL_Q0: begin
            if (mul_stat.done) begin
               q0_in         = q_sat.value;
               mul_req.start = 1'b1;
               mul_req.a     = gain_a;
               mul_req.b     = b_q1;
               state_in      = ST_MUL_Q1;
            end
         end
         ST_MUL_Q1: begin
            if (mul_stat.done) begin
               q1_in         = q_sat.value;
               mul_req.start = 1'b1;
               mul_req.a     = gain_a;
               mul_req.b     = b_q2;
               state_in      = ST_MUL_Q2;
            end
         end
         ST_MUL_Q2: begin
            if (mul_stat.done) begin
               q2_in         = q_sat.value;
               dirty_in      = 1'b0;
               mul_req.start = 1'b1;
               mul_req.a     = ipid_pkg::mul_a_type'(q0_ff);
               mul_req.b     = ipid_pkg::mul_b_type'(e_ff);
               state_in      = ST_MUL_E0;
            end
         end
         ST_MUL_E0: begin
            if (mul_stat.done) begin
               sum_in        = sum_next;
               mul_req.start = 1'b1;
               mul_req.a     = ipid_pkg::mul_a_type'(q1_ff);
               mul_req.b     = ipid_pkg::mul_b_type'(e1_ff);
               state_in      = ST_MUL_E1;
            end
         end
         ST_MUL_E1: begin
            if (mul_stat.done) begin
               sum_in        = sum_next;
               mul_req.start = 1'b1;
               mul_req.a     = ipid_pkg::mul_a_type'(q2_ff);
               mul_req.b     = ipid_pkg::mul_b_type'(e2_ff);
               state_in      = ST_MUL_E2;
            end
         end
         ST_MUL_E2: begin
            if (mul_stat.done) begin
               sum_in   = sum_next;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            u_in     = u_sat.value;
            clip_in  = u_sat.clip;
            e2_in    = e1_ff;
            e1_in    = e_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = u_ff;
               rsp_sat_in   = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            ipid_pkg::CSR_SETPOINT: begin
               setpoint_in = csr_wdata;
            end
            ipid_pkg::CSR_GAIN: begin
               gain_in  = csr_wdata;
               dirty_in = 1'b1;
            end
            ipid_pkg::CSR_SAMPLE_PERIOD: begin
               period_in = csr_wdata[ipid_pkg::TIME_W-1:0];
               dirty_in  = 1'b1;
            end
            ipid_pkg::CSR_DERIVATIVE_TIME: begin
               dtime_in = csr_wdata[ipid_pkg::TIME_W-1:0];
               dirty_in = 1'b1;
            end
            ipid_pkg::CSR_INTEGRAL_TIME: begin
               itime_in = csr_wdata[ipid_pkg::TIME_W-1:0];
               dirty_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // The clip flag is captured with the drive update and travels to the output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b1;
         setpoint_ff  <= '0;
         gain_ff      <= '0;
         period_ff    <= ipid_pkg::TIME_ONE;
         dtime_ff     <= '0;
         itime_ff     <= ipid_pkg::TIME_ONE;
         e1_ff        <= '0;
         e2_ff        <= '0;
         u_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_sat_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         setpoint_ff  <= setpoint_in;
         gain_ff      <= gain_in;
         period_ff    <= period_in;
         dtime_ff     <= dtime_in;
         itime_ff     <= itime_in;
         e1_ff        <= e1_in;
         e2_ff        <= e2_in;
         u_ff         <= u_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      ri_ff        <= ri_in;
      q0_ff        <= q0_in;
      q1_ff        <= q1_in;
      q2_ff        <= q2_in;
      e_ff         <= e_in;
      sum_ff       <= sum_in;
      clip_ff      <= clip_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_stat.busy && mul_stat.busy))
      else $error("divider and multiplier busy at the same time");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!div_stat.busy && !mul_stat.busy))
      else $error("arithmetic unit busy while waiting for an item");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (div_stat.busy || mul_stat.busy))
      else $error("accepted item did not start an arithmetic unit");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_drive == 32'sh7FFF_FFFF || rsp_drive == 32'sh8000_0000))
      else $error("clip flag set on a drive value that is not at a limit");

endmodule

FILE: bench/ipid_checker.sv
// Checker for the incremental PID controller: watches the register, measurement and
// drive channels, predicts each drive item and compares it with what the block returns.
// Depends on ipid_pkg.
module ipid_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  ipid_pkg::word_type            req_measurement,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ipid_pkg::word_type            rsp_drive,
   input  logic                          rsp_saturated,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  ipid_pkg::csr_index_type       csr_index,
   input  logic [ipid_pkg::DATA_W-1:0]   csr_wdata,
   output int                            failures,
   output int                            pending
);

   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct {
      ipid_pkg::word_type drive;
      logic               saturated;
   } drive_result_type;

   ipid_pkg::word_type cfg_setpoint;
   ipid_pkg::word_type cfg_gain;
   ipid_pkg::time_type cfg_period;
   ipid_pkg::time_type cfg_deriv;
   ipid_pkg::time_type cfg_integ;

   longint err_1;
   longint err_2;
   longint drive_acc;

   drive_result_type pending_drives[$];

   function automatic longint clip32(input longint v, output bit hit);
      hit = 1'b0;
      if (v > MAX32) begin
         hit = 1'b1;
         return MAX32;
      end
      if (v < MIN32) begin
         hit = 1'b1;
         return MIN32;
      end
      return v;
   endfunction

   function automatic longint time_ratio(input ipid_pkg::time_type num,
                                         input ipid_pkg::time_type den);
      longint d;
      longint r;
      d = (den == '0) ? 64'sd1 : longint'(den);
      r = (longint'(num) << ipid_pkg::FRAC_BITS) / d;
      return (r > longint'(ipid_pkg::RATIO_CAP)) ? longint'(ipid_pkg::RATIO_CAP) : r;
   endfunction

   function automatic drive_result_type predict_drive(input ipid_pkg::word_type measurement);
      drive_result_type res;
      bit     unused_hit;
      bit     hit;
      longint one;
      longint k;
      longint rd;
      longint ri;
      longint q0;
      longint q1;
      longint q2;
      longint e;
      longint delta;
      one = longint'(ipid_pkg::ONE);
      k   = longint'(cfg_gain);
      rd  = time_ratio(cfg_deriv, cfg_period);
      ri  = time_ratio(cfg_period, cfg_integ);
      q0  = clip32((k * (one + rd)) >>> ipid_pkg::FRAC_BITS, unused_hit);
      q1  = clip32((-(k * (one + 2 * rd - ri))) >>> ipid_pkg::FRAC_BITS, unused_hit);
      q2  = clip32((k * rd) >>> ipid_pkg::FRAC_BITS, unused_hit);
      e   = clip32(longint'(cfg_setpoint) - longint'(measurement), unused_hit);
      delta = ((q0 * e) >>> ipid_pkg::FRAC_BITS) + ((q1 * err_1) >>> ipid_pkg::FRAC_BITS)
            + ((q2 * err_2) >>> ipid_pkg::FRAC_BITS);
      drive_acc = clip32(drive_acc + delta, hit);
      err_2 = err_1;
      err_1 = e;
      res.drive     = ipid_pkg::word_type'(drive_acc);
      res.saturated = hit;
      return res;
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         cfg_setpoint = '0;
         cfg_gain     = '0;
         cfg_period   = ipid_pkg::TIME_ONE;
         cfg_deriv    = '0;
         cfg_integ    = ipid_pkg::TIME_ONE;
         err_1        = 0;
         err_2        = 0;
         drive_acc    = 0;
         pending_drives.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_drives.size() == 0) begin
               failures++;
               $display("%0t: drive expected no item, got %0d (saturated %0b)",
                        $time, rsp_drive, rsp_saturated);
            end else begin
               want = pending_drives.pop_front();
               if (rsp_drive !== want.drive) begin
                  failures++;
                  $display("%0t: drive expected %0d, got %0d",
                           $time, want.drive, rsp_drive);
               end
               if (rsp_saturated !== want.saturated) begin
                  failures++;
                  $display("%0t: saturated expected %0b, got %0b",
                           $time, want.saturated, rsp_saturated);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ipid_pkg::CSR_SETPOINT:
                  cfg_setpoint = ipid_pkg::word_type'(csr_wdata);
               ipid_pkg::CSR_GAIN:
                  cfg_gain     = ipid_pkg::word_type'(csr_wdata);
               ipid_pkg::CSR_SAMPLE_PERIOD:
                  cfg_period   = csr_wdata[ipid_pkg::TIME_W-1:0];
               ipid_pkg::CSR_DERIVATIVE_TIME:
                  cfg_deriv    = csr_wdata[ipid_pkg::TIME_W-1:0];
               ipid_pkg::CSR_INTEGRAL_TIME:
                  cfg_integ    = csr_wdata[ipid_pkg::TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_drives.push_back(predict_drive(req_measurement));
         end
      end
      pending = pending_drives.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the incremental PID controller bench: clock, reset, stimulus and verdict.
// Depends on ipid_pkg, incremental_pid_controller and ipid_checker.
module testbench;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 300;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 136;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   ipid_pkg::word_type            req_measurement = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   ipid_pkg::word_type            rsp_drive;
   logic                          rsp_saturated;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   ipid_pkg::csr_index_type       csr_index = '0;
   logic [ipid_pkg::DATA_W-1:0]   csr_wdata = '0;

   int                 failures;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 quiet_cycles = 0;
   ipid_pkg::word_type setpoint_now = '0;

   incremental_pid_controller u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ipid_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending         (pending)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic send_measurement(input ipid_pkg::word_type value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid       = 1'b0;
         req_measurement = ipid_pkg::word_type'($urandom);
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_measurement = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input ipid_pkg::csr_index_type index,
                            input logic [ipid_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == ipid_pkg::CSR_SETPOINT) setpoint_now = ipid_pkg::word_type'(data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [ipid_pkg::DATA_W-1:0] pick_value(
         input ipid_pkg::csr_index_type index);
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         5: return $urandom;
         default: begin
            case (index)
               ipid_pkg::CSR_SETPOINT: return $urandom_range(0, 1 << 23) - (1 << 22);
               ipid_pkg::CSR_GAIN:     return $urandom_range(0, 1 << 19) - (1 << 18);
               default:                return $urandom_range(1, 1 << 20);
            endcase
         end
      endcase
   endfunction

   function automatic ipid_pkg::word_type pick_measurement();
      case ($urandom_range(9))
         0: return ipid_pkg::word_type'(32'h8000_0000);
         1: return ipid_pkg::word_type'(32'h7FFF_FFFF);
         2, 3: return ipid_pkg::word_type'($urandom);
         default: return setpoint_now + ($urandom_range(0, 1 << 21) - (1 << 20));
      endcase
   endfunction

   task automatic randomize_settings();
      for (int idx = ipid_pkg::CSR_SETPOINT; idx <= ipid_pkg::CSR_INTEGRAL_TIME; idx++) begin
         if ($urandom_range(9) < 6) begin
            write_reg(ipid_pkg::csr_index_type'(idx),
                      pick_value(ipid_pkg::csr_index_type'(idx)));
         end
      end
      if ($urandom_range(3) == 0) begin
         write_reg(ipid_pkg::csr_index_type'($urandom_range(ipid_pkg::CSR_INTEGRAL_TIME + 1,
                   (1 << ipid_pkg::CSR_IDX_W) - 1)), $urandom);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: zero gain keeps the drive at zero.
      send_measurement('0);
      send_measurement(ipid_pkg::word_type'(32'h7FFF_FFFF));

      // Error overflow: the largest setpoint against the most negative measurement.
      wait_drain();
      write_reg(ipid_pkg::CSR_SETPOINT, 32'h7FFF_FFFF);
      write_reg(ipid_pkg::CSR_GAIN, 32'h0001_0000);
      send_measurement(ipid_pkg::word_type'(32'h8000_0000));
      send_measurement(ipid_pkg::word_type'(32'h7FFF_FFFF));
      send_measurement(ipid_pkg::word_type'(32'hFFFF_FFFF));

      // Zero period and integral time, a capped derivative ratio and a saturating accumulator.
      wait_drain();
      write_reg(ipid_pkg::CSR_SAMPLE_PERIOD, 32'h0000_0000);
      write_reg(ipid_pkg::CSR_INTEGRAL_TIME, 32'h0000_0000);
      write_reg(ipid_pkg::CSR_DERIVATIVE_TIME, 32'hFFFF_FFFF);
      write_reg(ipid_pkg::CSR_GAIN, 32'h8000_0000);
      write_reg(ipid_pkg::CSR_SETPOINT, 32'h8000_0000);
      send_measurement(ipid_pkg::word_type'(32'h7FFF_FFFF));
      send_measurement('0);
      send_measurement(ipid_pkg::word_type'(32'h8000_0000));
      send_measurement(ipid_pkg::word_type'(32'h0000_0001));

      // Writes to unused indexes must leave the settings alone.
      wait_drain();
      for (int idx = ipid_pkg::CSR_INTEGRAL_TIME + 1; idx < (1 << ipid_pkg::CSR_IDX_W);
           idx++) begin
         write_reg(ipid_pkg::csr_index_type'(idx), $urandom);
      end
      write_reg(ipid_pkg::CSR_GAIN, 32'h7FFF_FFFF);
      write_reg(ipid_pkg::CSR_SAMPLE_PERIOD, 32'hFFFF_FFFF);
      write_reg(ipid_pkg::CSR_INTEGRAL_TIME, 32'h7FFF_FFFF);
      write_reg(ipid_pkg::CSR_DERIVATIVE_TIME, 32'h0000_0000);
      send_measurement(ipid_pkg::word_type'(32'h8000_0000));
      send_measurement(ipid_pkg::word_type'(32'h7FFF_FFFF));

      // A plain loop: w = 1.0, K = 0.5, T0 = 0.1, TD = 0.05, T = 2.0.
      wait_drain();
      write_reg(ipid_pkg::CSR_SETPOINT, 32'h0001_0000);
      write_reg(ipid_pkg::CSR_GAIN, 32'h0000_8000);
      write_reg(ipid_pkg::CSR_SAMPLE_PERIOD, 32'h0000_199A);
      write_reg(ipid_pkg::CSR_DERIVATIVE_TIME, 32'h0000_0CCD);
      write_reg(ipid_pkg::CSR_INTEGRAL_TIME, 32'h0002_0000);
      for (int n = 0; n < 5; n++) send_measurement(ipid_pkg::word_type'(n * 32'h0000_4000));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drain();
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         randomize_settings();
         repeat (ITEMS_PER_PHASE) send_measurement(pick_measurement());
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/ipid_pkg.sv
design/ipid_div.sv
design/ipid_mul.sv
design/incremental_pid_controller.sv
bench/ipid_checker.sv
bench/testbench.sv
